### rtl/core/ase_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ase_pkg;

	localparam int RegCount = 16;
	localparam int RegIdxW  = $clog2(RegCount);
	localparam int WordW    = 32;
	localparam int FlagW    = 4;
	localparam int ArgCount = 4;
	localparam int CfgIdxW  = 3;

	localparam logic [RegIdxW-1:0] PcIndex   = RegIdxW'(15);
	localparam logic [RegIdxW-1:0] LinkIndex = RegIdxW'(14);

	localparam logic [WordW-1:0] StartReset = 32'hFFFF_0040;
	localparam logic [WordW-1:0] ArgReset   = 32'h0000_0000;

	// bits 27..4 of a BX word
	localparam logic [23:0] BxPattern = 24'h12FFF1;
	localparam logic [2:0]  BranchClass = 3'b101;
	localparam logic [1:0]  DataProcClass = 2'b00;

	// configuration register indexes
	localparam logic [CfgIdxW-1:0] CfgStart = 3'd0;
	localparam logic [CfgIdxW-1:0] CfgArg0  = 3'd1;
	localparam logic [CfgIdxW-1:0] CfgArg1  = 3'd2;
	localparam logic [CfgIdxW-1:0] CfgArg2  = 3'd3;
	localparam logic [CfgIdxW-1:0] CfgArg3  = 3'd4;

	// data processing opcodes
	localparam logic [3:0] OpSub = 4'd2;
	localparam logic [3:0] OpAdd = 4'd4;
	localparam logic [3:0] OpCmp = 4'd10;
	localparam logic [3:0] OpCmn = 4'd11;
	localparam logic [3:0] OpMov = 4'd13;
	localparam logic [3:0] OpMvn = 4'd15;

	// condition codes
	localparam logic [3:0] CondEq = 4'd0;
	localparam logic [3:0] CondNe = 4'd1;
	localparam logic [3:0] CondCs = 4'd2;
	localparam logic [3:0] CondCc = 4'd3;
	localparam logic [3:0] CondMi = 4'd4;
	localparam logic [3:0] CondPl = 4'd5;
	localparam logic [3:0] CondVs = 4'd6;
	localparam logic [3:0] CondVc = 4'd7;
	localparam logic [3:0] CondHi = 4'd8;
	localparam logic [3:0] CondLs = 4'd9;
	localparam logic [3:0] CondGe = 4'd10;
	localparam logic [3:0] CondLt = 4'd11;
	localparam logic [3:0] CondGt = 4'd12;
	localparam logic [3:0] CondLe = 4'd13;
	localparam logic [3:0] CondAl = 4'd14;

	// flag bit positions within nzcv
	localparam int FlagN = 3;
	localparam int FlagZ = 2;
	localparam int FlagC = 1;
	localparam int FlagV = 0;

	typedef struct packed {
		logic               restart;
		logic               we;
		logic [RegIdxW-1:0] idx;
		logic [WordW-1:0]   data;
	} wr_req_t;

	typedef struct packed {
		logic               condition_passed;
		logic               unsupported;
		logic               dest_written;
		logic [RegIdxW-1:0] dest_index;
		logic [WordW-1:0]   written_value;
		logic [WordW-1:0]   next_pc;
		logic [FlagW-1:0]   flags_nzcv;
	} res_t;

endpackage

`default_nettype wire

### rtl/core/ase_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface ase_in_if;
	logic                      valid;
	logic                      ready;
	logic [ase_pkg::WordW-1:0] instruction_word;
	logic                      restart;

	modport source (output valid, output instruction_word, output restart, input ready);
	modport sink (input valid, input instruction_word, input restart, output ready);
endinterface

interface ase_out_if;
	logic                        valid;
	logic                        ready;
	logic                        condition_passed;
	logic                        unsupported;
	logic                        dest_written;
	logic [ase_pkg::RegIdxW-1:0] dest_index;
	logic [ase_pkg::WordW-1:0]   written_value;
	logic [ase_pkg::WordW-1:0]   next_pc;
	logic [ase_pkg::FlagW-1:0]   flags_nzcv;

	modport source (output valid, output condition_passed, output unsupported,
		output dest_written, output dest_index, output written_value, output next_pc,
		output flags_nzcv, input ready);
	modport sink (input valid, input condition_passed, input unsupported,
		input dest_written, input dest_index, input written_value, input next_pc,
		input flags_nzcv, output ready);
endinterface

`default_nettype wire

### rtl/core/ase_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module ase_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

### rtl/core/ase_regfile.sv
`timescale 1ns / 1ps
`default_nettype none

module ase_regfile (
	input  wire logic                                              clk,
	input  wire logic                                              arst_n,
	input  wire logic                                              rd_en,
	input  wire logic [ase_pkg::RegIdxW-1:0]                       ra_n,
	input  wire logic [ase_pkg::RegIdxW-1:0]                       ra_m,
	input  wire ase_pkg::wr_req_t                                  wr,
	input  wire logic [ase_pkg::ArgCount-1:0][ase_pkg::WordW-1:0] args,
	output logic      [ase_pkg::WordW-1:0]                         rn_val,
	output logic      [ase_pkg::WordW-1:0]                         rm_val
);

	logic [ase_pkg::WordW-1:0]                       ram_n_data;
	logic [ase_pkg::WordW-1:0]                       ram_m_data;
	logic [ase_pkg::RegIdxW-1:0]                     ra_n_s1;
	logic [ase_pkg::RegIdxW-1:0]                     ra_m_s1;
	logic [ase_pkg::RegCount-1:0]                    valid_q;
	logic [ase_pkg::ArgCount-1:0][ase_pkg::WordW-1:0] snap_q;
	logic                                            fwd_valid_q;
	logic [ase_pkg::RegIdxW-1:0]                     fwd_idx_q;
	logic [ase_pkg::WordW-1:0]                       fwd_data_q;

	// two copies give two read ports; both take every write
	ase_ram #(.WIDTH(ase_pkg::WordW), .DEPTH(ase_pkg::RegCount)) u_ram_n (
		.clk   (clk),
		.we    (wr.we),
		.waddr (wr.idx),
		.wdata (wr.data),
		.re    (rd_en),
		.raddr (ra_n),
		.rdata (ram_n_data)
	);

	ase_ram #(.WIDTH(ase_pkg::WordW), .DEPTH(ase_pkg::RegCount)) u_ram_m (
		.clk   (clk),
		.we    (wr.we),
		.waddr (wr.idx),
		.wdata (wr.data),
		.re    (rd_en),
		.raddr (ra_m),
		.rdata (ram_m_data)
	);

	always_ff @(posedge clk) begin
		if (rd_en) begin
			ra_n_s1 <= ra_n;
			ra_m_s1 <= ra_m;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			fwd_valid_q <= 1'b0;
			snap_q      <= {ase_pkg::ArgCount{ase_pkg::ArgReset}};
		end else if (wr.restart) begin
			valid_q     <= '0;
			fwd_valid_q <= 1'b0;
			snap_q      <= args;
		end else if (wr.we) begin
			valid_q[wr.idx] <= 1'b1;
			fwd_valid_q     <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr.we) begin
			fwd_idx_q  <= wr.idx;
			fwd_data_q <= wr.data;
		end
	end

	// the last write may have landed in the same cycle as the read: take it from the bypass
	always_comb begin
		if (fwd_valid_q && fwd_idx_q == ra_n_s1) begin
			rn_val = fwd_data_q;
		end else if (valid_q[ra_n_s1]) begin
			rn_val = ram_n_data;
		end else if (ra_n_s1[ase_pkg::RegIdxW-1:2] == '0) begin
			rn_val = snap_q[ra_n_s1[1:0]];
		end else begin
			rn_val = '0;
		end

		if (fwd_valid_q && fwd_idx_q == ra_m_s1) begin
			rm_val = fwd_data_q;
		end else if (valid_q[ra_m_s1]) begin
			rm_val = ram_m_data;
		end else if (ra_m_s1[ase_pkg::RegIdxW-1:2] == '0) begin
			rm_val = snap_q[ra_m_s1[1:0]];
		end else begin
			rm_val = '0;
		end
	end

endmodule

`default_nettype wire

### rtl/core/ase_exec.sv
`timescale 1ns / 1ps
`default_nettype none

module ase_exec (
	input  wire logic                          restart,
	input  wire logic [ase_pkg::WordW-1:0]     word,
	input  wire logic [ase_pkg::WordW-1:0]     start_address,
	input  wire logic [ase_pkg::WordW-1:0]     pc,
	input  wire logic [ase_pkg::FlagW-1:0]     flags,
	input  wire logic [ase_pkg::WordW-1:0]     rn_raw,
	input  wire logic [ase_pkg::WordW-1:0]     rm_raw,
	output ase_pkg::res_t                      res,
	output logic                               reg_we,
	output logic      [ase_pkg::RegIdxW-1:0]   reg_idx,
	output logic      [ase_pkg::WordW-1:0]     reg_data
);

	function automatic logic cond_ok(input logic [3:0] cond, input logic [3:0] f);
		logic n, z, c, v, ok;
		n = f[ase_pkg::FlagN];
		z = f[ase_pkg::FlagZ];
		c = f[ase_pkg::FlagC];
		v = f[ase_pkg::FlagV];
		case (cond)
			ase_pkg::CondEq: ok = z;
			ase_pkg::CondNe: ok = !z;
			ase_pkg::CondCs: ok = c;
			ase_pkg::CondCc: ok = !c;
			ase_pkg::CondMi: ok = n;
			ase_pkg::CondPl: ok = !n;
			ase_pkg::CondVs: ok = v;
			ase_pkg::CondVc: ok = !v;
			ase_pkg::CondHi: ok = c && !z;
			ase_pkg::CondLs: ok = !c || z;
			ase_pkg::CondGe: ok = n == v;
			ase_pkg::CondLt: ok = n != v;
			ase_pkg::CondGt: ok = !z && (n == v);
			ase_pkg::CondLe: ok = z || (n != v);
			ase_pkg::CondAl: ok = 1'b1;
			default:         ok = 1'b0;
		endcase
		return ok;
	endfunction

	logic                        pass;
	logic [ase_pkg::WordW-1:0]   pc4;
	logic [ase_pkg::WordW-1:0]   pc8;
	logic [ase_pkg::WordW-1:0]   a;
	logic [ase_pkg::WordW-1:0]   rm_val;
	logic [ase_pkg::WordW-1:0]   b;
	logic [ase_pkg::WordW-1:0]   r;
	logic [ase_pkg::WordW-1:0]   br_off;
	logic [4:0]                  rot;
	logic [2*ase_pkg::WordW-1:0] imm_wide;
	logic [ase_pkg::WordW:0]     sum_add;
	logic [ase_pkg::WordW:0]     sum_sub;
	logic [3:0]                  op;
	logic                        ibit;
	logic                        sbit;
	logic                        is_bx;
	logic                        is_b;
	logic                        is_dp;
	logic                        dp_ok;
	logic                        dp_wr;
	logic                        cf;
	logic                        vf;
	logic [ase_pkg::RegIdxW-1:0] rd;

	always_comb begin
		pass  = cond_ok(word[31:28], flags);
		pc4   = pc + 32'd4;
		pc8   = pc + 32'd8;
		op    = word[24:21];
		ibit  = word[25];
		sbit  = word[20];
		rd    = word[15:12];
		is_bx = word[27:4] == ase_pkg::BxPattern;
		is_b  = word[27:25] == ase_pkg::BranchClass;
		is_dp = word[27:26] == ase_pkg::DataProcClass;

		// r15 reads as the instruction address plus eight
		a      = (word[19:16] == ase_pkg::PcIndex) ? pc8 : rn_raw;
		rm_val = (word[3:0] == ase_pkg::PcIndex) ? pc8 : rm_raw;

		br_off = {{6{word[23]}}, word[23:0], 2'b00};

		rot      = {word[11:8], 1'b0};
		imm_wide = {24'd0, word[7:0], 24'd0, word[7:0]} >> rot;
		b        = ibit ? imm_wide[ase_pkg::WordW-1:0] : rm_val;

		sum_add = {1'b0, a} + {1'b0, b};
		sum_sub = {1'b0, a} + {1'b0, ~b} + 33'd1;

		dp_ok = op == ase_pkg::OpSub || op == ase_pkg::OpAdd || op == ase_pkg::OpMov ||
			op == ase_pkg::OpMvn || ((op == ase_pkg::OpCmp || op == ase_pkg::OpCmn) && sbit);
		if (!ibit && word[11:4] != 8'd0) begin
			dp_ok = 1'b0;
		end
		dp_wr = op == ase_pkg::OpSub || op == ase_pkg::OpAdd || op == ase_pkg::OpMov ||
			op == ase_pkg::OpMvn;

		cf = flags[ase_pkg::FlagC];
		vf = flags[ase_pkg::FlagV];
		if (ibit && rot != 5'd0) begin
			cf = b[31];
		end
		if (op == ase_pkg::OpSub || op == ase_pkg::OpCmp) begin
			r  = sum_sub[ase_pkg::WordW-1:0];
			cf = sum_sub[ase_pkg::WordW];
			vf = (a[31] ^ b[31]) & (a[31] ^ r[31]);
		end else if (op == ase_pkg::OpAdd || op == ase_pkg::OpCmn) begin
			r  = sum_add[ase_pkg::WordW-1:0];
			cf = sum_add[ase_pkg::WordW];
			vf = ~(a[31] ^ b[31]) & (a[31] ^ r[31]);
		end else if (op == ase_pkg::OpMov) begin
			r = b;
		end else begin
			r = ~b;
		end

		res                  = '0;
		res.next_pc          = pc;
		res.flags_nzcv       = flags;
		reg_we               = 1'b0;
		reg_idx              = rd;
		reg_data             = r;

		if (restart) begin
			res.next_pc    = start_address;
			res.flags_nzcv = '0;
		end else if (is_bx) begin
			res.condition_passed = pass;
			res.next_pc          = pass ? {rm_val[31:1], 1'b0} : pc4;
		end else if (is_b) begin
			res.condition_passed = pass;
			res.next_pc          = pass ? pc8 + br_off : pc4;
			if (pass && word[24]) begin
				res.dest_written  = 1'b1;
				res.dest_index    = ase_pkg::LinkIndex;
				res.written_value = pc4;
				reg_we            = 1'b1;
				reg_idx           = ase_pkg::LinkIndex;
				reg_data          = pc4;
			end
		end else if (is_dp && dp_ok) begin
			res.condition_passed = pass;
			res.next_pc          = pc4;
			if (pass) begin
				if (sbit) begin
					res.flags_nzcv = {r[31], r == '0, cf, vf};
				end
				if (dp_wr) begin
					res.dest_written  = 1'b1;
					res.dest_index    = rd;
					res.written_value = r;
					// a write to r15 is a jump and stays out of the file
					if (rd == ase_pkg::PcIndex) begin
						res.next_pc = r;
					end else begin
						reg_we = 1'b1;
					end
				end
			end
		end else begin
			res.unsupported = 1'b1;
		end
	end

endmodule

`default_nettype wire

### rtl/core/arm_subset_execute_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Payload                                         Transfer
// instr     in   instruction_word[31:0], restart                 valid & ready
// result    out  passed, unsupported, dest, value, next_pc, nzcv valid & ready
// config    in   reg_index[2:0], write_data[31:0]                write_enable
//
// One instruction per cycle unless the result channel stalls. An instruction goes
// through the register file read (synchronous RAM), then execute, where PC, flags
// and the file are updated; a bypass covers a write that meets the next read.
// Results wait in an output register, so a new instruction is taken while one is
// unread. Restart reloads PC, flags and arguments; reset needs no clearing pass.

module arm_subset_execute_unit (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	ase_in_if.sink                             instr,
	ase_out_if.source                          result,
	input  wire logic                          write_enable,
	input  wire logic [ase_pkg::CfgIdxW-1:0]   reg_index,
	input  wire logic [ase_pkg::WordW-1:0]     write_data
);

	logic [ase_pkg::WordW-1:0]                        start_q;
	logic [ase_pkg::ArgCount-1:0][ase_pkg::WordW-1:0] arg_q;
	logic [ase_pkg::WordW-1:0]                        pc_q;
	logic [ase_pkg::FlagW-1:0]                        flags_q;
	logic                                             valid_s1;
	logic [ase_pkg::WordW-1:0]                        word_s1;
	logic                                             restart_s1;
	logic                                             out_valid_q;
	ase_pkg::res_t                                    res_q;
	ase_pkg::res_t                                    res;
	ase_pkg::wr_req_t                                 wr;
	logic                                             go;
	logic                                             accept;
	logic                                             ex_we;
	logic [ase_pkg::RegIdxW-1:0]                      ex_idx;
	logic [ase_pkg::WordW-1:0]                        ex_data;
	logic [ase_pkg::WordW-1:0]                        rn_val;
	logic [ase_pkg::WordW-1:0]                        rm_val;

	// execute commits only when the output register can take the result
	assign go          = valid_s1 && (!out_valid_q || result.ready);
	assign instr.ready = !valid_s1 || go;
	assign accept      = instr.valid && instr.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= ase_pkg::StartReset;
			arg_q   <= {ase_pkg::ArgCount{ase_pkg::ArgReset}};
		end else if (write_enable) begin
			case (reg_index)
				ase_pkg::CfgStart: start_q  <= write_data;
				ase_pkg::CfgArg0:  arg_q[0] <= write_data;
				ase_pkg::CfgArg1:  arg_q[1] <= write_data;
				ase_pkg::CfgArg2:  arg_q[2] <= write_data;
				ase_pkg::CfgArg3:  arg_q[3] <= write_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			pc_q        <= ase_pkg::StartReset;
			flags_q     <= '0;
		end else begin
			if (instr.ready) begin
				valid_s1 <= instr.valid;
			end
			if (go) begin
				out_valid_q <= 1'b1;
				pc_q        <= res.next_pc;
				flags_q     <= res.flags_nzcv;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			word_s1    <= instr.instruction_word;
			restart_s1 <= instr.restart;
		end
		if (go) begin
			res_q <= res;
		end
	end

	always_comb begin
		wr         = '0;
		wr.restart = go && restart_s1;
		wr.we      = go && ex_we;
		wr.idx     = ex_idx;
		wr.data    = ex_data;
	end

	ase_regfile u_regfile (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_en  (accept),
		.ra_n   (instr.instruction_word[19:16]),
		.ra_m   (instr.instruction_word[3:0]),
		.wr     (wr),
		.args   (arg_q),
		.rn_val (rn_val),
		.rm_val (rm_val)
	);

	ase_exec u_exec (
		.restart       (restart_s1),
		.word          (word_s1),
		.start_address (start_q),
		.pc            (pc_q),
		.flags         (flags_q),
		.rn_raw        (rn_val),
		.rm_raw        (rm_val),
		.res           (res),
		.reg_we        (ex_we),
		.reg_idx       (ex_idx),
		.reg_data      (ex_data)
	);

	assign result.valid            = out_valid_q;
	assign result.condition_passed = res_q.condition_passed;
	assign result.unsupported      = res_q.unsupported;
	assign result.dest_written     = res_q.dest_written;
	assign result.dest_index       = res_q.dest_index;
	assign result.written_value    = res_q.written_value;
	assign result.next_pc          = res_q.next_pc;
	assign result.flags_nzcv       = res_q.flags_nzcv;

endmodule

`default_nettype wire

### dv/testbench.sv
`timescale 1ns / 1ps

module testbench;

	localparam int          CycleLimit = 400000;
	localparam int          PhaseItems = 500;
	localparam int          TailCycles = 10;
	localparam logic [3:0]  OpAnd      = 4'd0;
	localparam logic [3:0]  CondNever  = 4'd15;

	class exec_scoreboard;
		logic [ase_pkg::WordW-1:0] gpr [ase_pkg::RegCount];
		logic [ase_pkg::FlagW-1:0] flags;
		logic [ase_pkg::WordW-1:0] start_pc;
		logic [ase_pkg::WordW-1:0] args [ase_pkg::ArgCount];
		ase_pkg::res_t             expected_results [$];
		int unsigned               failures;

		function new();
			for (int i = 0; i < ase_pkg::RegCount; i++) gpr[i] = '0;
			for (int i = 0; i < ase_pkg::ArgCount; i++) args[i] = ase_pkg::ArgReset;
			start_pc = ase_pkg::StartReset;
			gpr[ase_pkg::PcIndex] = ase_pkg::StartReset;
			flags = '0;
			failures = 0;
		endfunction

		function void set_config(logic [ase_pkg::CfgIdxW-1:0] idx,
			logic [ase_pkg::WordW-1:0] val);
			case (idx)
				ase_pkg::CfgStart: start_pc = val;
				ase_pkg::CfgArg0:  args[0] = val;
				ase_pkg::CfgArg1:  args[1] = val;
				ase_pkg::CfgArg2:  args[2] = val;
				ase_pkg::CfgArg3:  args[3] = val;
				default: ;
			endcase
		endfunction

		function logic [ase_pkg::WordW-1:0] read_operand(logic [ase_pkg::RegIdxW-1:0] idx,
			logic [ase_pkg::WordW-1:0] pc);
			return (idx == ase_pkg::PcIndex) ? pc + 32'd8 : gpr[idx];
		endfunction

		function bit cond_holds(logic [3:0] cond);
			logic n, z, c, v;
			n = flags[ase_pkg::FlagN];
			z = flags[ase_pkg::FlagZ];
			c = flags[ase_pkg::FlagC];
			v = flags[ase_pkg::FlagV];
			case (cond)
				ase_pkg::CondEq: return z;
				ase_pkg::CondNe: return !z;
				ase_pkg::CondCs: return c;
				ase_pkg::CondCc: return !c;
				ase_pkg::CondMi: return n;
				ase_pkg::CondPl: return !n;
				ase_pkg::CondVs: return v;
				ase_pkg::CondVc: return !v;
				ase_pkg::CondHi: return c && !z;
				ase_pkg::CondLs: return !c || z;
				ase_pkg::CondGe: return n == v;
				ase_pkg::CondLt: return n != v;
				ase_pkg::CondGt: return !z && (n == v);
				ase_pkg::CondLe: return z || (n != v);
				ase_pkg::CondAl: return 1'b1;
				default: return 1'b0;
			endcase
		endfunction

		// work out the result of one accepted instruction and advance the state
		function void note_instruction(logic [ase_pkg::WordW-1:0] w, logic rs);
			ase_pkg::res_t             e;
			logic [ase_pkg::WordW-1:0] pc, npc, a, b, r, imm, off;
			logic [63:0]               wide;
			logic [32:0]               sum;
			logic [3:0]                op;
			logic [4:0]                rot;
			logic                      c, v, ok;
			e = '0;
			pc = gpr[ase_pkg::PcIndex];
			npc = pc;
			if (rs) begin
				for (int i = 0; i < ase_pkg::RegCount; i++) gpr[i] = '0;
				for (int i = 0; i < ase_pkg::ArgCount; i++) gpr[i] = args[i];
				flags = '0;
				npc = start_pc;
			end else if (w[27:4] == ase_pkg::BxPattern) begin
				if (cond_holds(w[31:28])) begin
					e.condition_passed = 1'b1;
					npc = read_operand(w[3:0], pc) & ~32'd1;
				end else begin
					npc = pc + 32'd4;
				end
			end else if (w[27:25] == ase_pkg::BranchClass) begin
				if (cond_holds(w[31:28])) begin
					e.condition_passed = 1'b1;
					off = {{6{w[23]}}, w[23:0], 2'b00};
					if (w[24]) begin
						e.dest_written = 1'b1;
						e.dest_index = ase_pkg::LinkIndex;
						e.written_value = pc + 32'd4;
						gpr[ase_pkg::LinkIndex] = pc + 32'd4;
					end
					npc = pc + 32'd8 + off;
				end else begin
					npc = pc + 32'd4;
				end
			end else if (w[27:26] == ase_pkg::DataProcClass) begin
				op = w[24:21];
				ok = (op == ase_pkg::OpSub) || (op == ase_pkg::OpAdd) ||
					(op == ase_pkg::OpMov) || (op == ase_pkg::OpMvn) ||
					((op == ase_pkg::OpCmp || op == ase_pkg::OpCmn) && w[20]);
				if (!w[25] && w[11:4] != 8'd0)
					ok = 1'b0;
				if (!ok) begin
					e.unsupported = 1'b1;
				end else if (!cond_holds(w[31:28])) begin
					npc = pc + 32'd4;
				end else begin
					e.condition_passed = 1'b1;
					npc = pc + 32'd4;
					a = read_operand(w[19:16], pc);
					c = flags[ase_pkg::FlagC];
					v = flags[ase_pkg::FlagV];
					if (w[25]) begin
						rot = {w[11:8], 1'b0};
						imm = {24'd0, w[7:0]};
						wide = {imm, imm} >> rot;
						b = wide[31:0];
						if (rot != 5'd0)
							c = b[31];
					end else begin
						b = read_operand(w[3:0], pc);
					end
					if (op == ase_pkg::OpSub || op == ase_pkg::OpCmp) begin
						r = a - b;
						c = (a >= b);
						v = (a[31] ^ b[31]) & (a[31] ^ r[31]);
					end else if (op == ase_pkg::OpAdd || op == ase_pkg::OpCmn) begin
						sum = {1'b0, a} + {1'b0, b};
						r = sum[31:0];
						c = sum[32];
						v = ~(a[31] ^ b[31]) & (a[31] ^ r[31]);
					end else if (op == ase_pkg::OpMov) begin
						r = b;
					end else begin
						r = ~b;
					end
					if (w[20])
						flags = {r[31], r == '0, c, v};
					if (op != ase_pkg::OpCmp && op != ase_pkg::OpCmn) begin
						e.dest_written = 1'b1;
						e.dest_index = w[15:12];
						e.written_value = r;
						if (w[15:12] == ase_pkg::PcIndex)
							npc = r;
						else
							gpr[w[15:12]] = r;
					end
				end
			end else begin
				e.unsupported = 1'b1;
			end
			gpr[ase_pkg::PcIndex] = npc;
			e.next_pc = npc;
			e.flags_nzcv = flags;
			expected_results.push_back(e);
		endfunction

		function void check_result(ase_pkg::res_t got);
			ase_pkg::res_t e;
			if (expected_results.size() == 0) begin
				failures++;
				if (failures <= 10)
					$display("unexpected result: pc=%h", got.next_pc);
				return;
			end
			e = expected_results.pop_front();
			if (got.condition_passed !== e.condition_passed ||
				got.unsupported !== e.unsupported ||
				got.dest_written !== e.dest_written || got.dest_index !== e.dest_index ||
				got.written_value !== e.written_value || got.next_pc !== e.next_pc ||
				got.flags_nzcv !== e.flags_nzcv) begin
				failures++;
				if (failures <= 10)
					$display("mismatch: exp p%0d u%0d w%0d r%0d %h pc %h f%h",
						e.condition_passed, e.unsupported, e.dest_written, e.dest_index,
						e.written_value, e.next_pc, e.flags_nzcv,
						", got p%0d u%0d w%0d r%0d %h pc %h f%h",
						got.condition_passed, got.unsupported, got.dest_written,
						got.dest_index, got.written_value, got.next_pc, got.flags_nzcv);
			end
		endfunction
	endclass

	logic                        clk;
	logic                        arst_n;
	logic                        write_enable;
	logic [ase_pkg::CfgIdxW-1:0] reg_index;
	logic [ase_pkg::WordW-1:0]   write_data;
	logic                        out_ready = 1'b0;
	int                          in_idle_pct;
	int                          out_idle_pct;
	int unsigned                 cycles = 0;
	exec_scoreboard              sb = new();

	ase_in_if  instr_ch ();
	ase_out_if res_ch ();

	assign res_ch.ready = out_ready;

	arm_subset_execute_unit u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.instr        (instr_ch),
		.result       (res_ch),
		.write_enable (write_enable),
		.reg_index    (reg_index),
		.write_data   (write_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("testbench: errors");
			$finish;
		end
	end

	always @(posedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= out_idle_pct);
	end

	always @(posedge clk) begin : result_monitor
		ase_pkg::res_t got;
		if (res_ch.valid && res_ch.ready) begin
			got.condition_passed = res_ch.condition_passed;
			got.unsupported = res_ch.unsupported;
			got.dest_written = res_ch.dest_written;
			got.dest_index = res_ch.dest_index;
			got.written_value = res_ch.written_value;
			got.next_pc = res_ch.next_pc;
			got.flags_nzcv = res_ch.flags_nzcv;
			sb.check_result(got);
		end
	end

	function automatic logic [31:0] dp_word(logic [3:0] cond, logic ibit, logic [3:0] op,
		logic s, logic [3:0] rn, logic [3:0] rd, logic [11:0] opnd);
		return {cond, ase_pkg::DataProcClass, ibit, op, s, rn, rd, opnd};
	endfunction

	function automatic logic [31:0] branch_word(logic [3:0] cond, logic link,
		logic [23:0] off);
		return {cond, ase_pkg::BranchClass, link, off};
	endfunction

	function automatic logic [31:0] bx_word(logic [3:0] cond, logic [3:0] rm);
		return {cond, ase_pkg::BxPattern, rm};
	endfunction

	task automatic send(input logic [31:0] w, input logic rs);
		while ($urandom_range(0, 99) < in_idle_pct) begin
			instr_ch.valid <= 1'b0;
			@(posedge clk);
		end
		instr_ch.valid <= 1'b1;
		instr_ch.instruction_word <= w;
		instr_ch.restart <= rs;
		do @(posedge clk); while (!instr_ch.ready);
		sb.note_instruction(w, rs);
	endtask

	// hold the sender until every transfer has come back
	task automatic drain();
		instr_ch.valid <= 1'b0;
		while (sb.expected_results.size() != 0) @(posedge clk);
		repeat (TailCycles) @(posedge clk);
	endtask

	task automatic write_reg(input logic [ase_pkg::CfgIdxW-1:0] idx,
		input logic [ase_pkg::WordW-1:0] val);
		write_enable <= 1'b1;
		reg_index <= idx;
		write_data <= val;
		@(posedge clk);
		sb.set_config(idx, val);
	endtask

	task automatic configure(input logic [ase_pkg::WordW-1:0] pc,
		input logic [ase_pkg::WordW-1:0] a0, input logic [ase_pkg::WordW-1:0] a1,
		input logic [ase_pkg::WordW-1:0] a2, input logic [ase_pkg::WordW-1:0] a3);
		write_reg(ase_pkg::CfgStart, pc);
		write_reg(ase_pkg::CfgArg0, a0);
		write_reg(ase_pkg::CfgArg1, a1);
		write_reg(ase_pkg::CfgArg2, a2);
		write_reg(ase_pkg::CfgArg3, a3);
		write_enable <= 1'b0;
	endtask

	// mostly well-formed instructions, the rest noise and restarts
	task automatic pick_random(output logic [31:0] w, output logic rs);
		int          kind;
		logic [3:0]  cond, op;
		logic [11:0] opnd;
		logic        ibit, s;
		kind = $urandom_range(0, 99);
		cond = ($urandom_range(0, 9) < 7) ? ase_pkg::CondAl : 4'($urandom_range(0, 15));
		rs = 1'b0;
		w = $urandom;
		if (kind < 3) begin
			rs = 1'b1;
		end else if (kind < 58) begin
			case ($urandom_range(0, 5))
				0: op = ase_pkg::OpSub;
				1: op = ase_pkg::OpAdd;
				2: op = ase_pkg::OpCmp;
				3: op = ase_pkg::OpCmn;
				4: op = ase_pkg::OpMov;
				default: op = ase_pkg::OpMvn;
			endcase
			if ($urandom_range(0, 9) == 0)
				op = 4'($urandom);
			ibit = 1'($urandom_range(0, 1));
			opnd = 12'($urandom);
			if (!ibit && $urandom_range(0, 9) != 0)
				opnd[11:4] = 8'd0;
			if (op == ase_pkg::OpCmp || op == ase_pkg::OpCmn)
				s = ($urandom_range(0, 9) != 0);
			else
				s = 1'($urandom_range(0, 1));
			w = dp_word(cond, ibit, op, s, 4'($urandom), 4'($urandom), opnd);
		end else if (kind < 72) begin
			w = branch_word(cond, 1'($urandom_range(0, 1)), 24'($urandom));
		end else if (kind < 80) begin
			w = bx_word(cond, 4'($urandom));
		end
	endtask

	task automatic run_random(input int count, input bit pause_midway);
		logic [31:0] w;
		logic        rs;
		send(32'($urandom), 1'b1);
		for (int i = 0; i < count; i++) begin
			if (pause_midway && i == count / 2)
				drain();
			pick_random(w, rs);
			send(w, rs);
		end
	endtask

	initial begin
		instr_ch.valid = 1'b0;
		instr_ch.instruction_word = '0;
		instr_ch.restart = 1'b0;
		write_enable = 1'b0;
		reg_index = ase_pkg::CfgStart;
		write_data = '0;
		arst_n = 1'b0;
		in_idle_pct = 34;
		out_idle_pct = 49;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send(32'hFFFF_FFFF, 1'b1);
		send(dp_word(ase_pkg::CondAl, 1'b1, ase_pkg::OpMov, 1'b1, 4'd0, 4'd0, 12'h0FF), 1'b0);
		send(dp_word(ase_pkg::CondAl, 1'b1, ase_pkg::OpMov, 1'b1, 4'd0, 4'd1, 12'h102), 1'b0);
		send(dp_word(ase_pkg::CondAl, 1'b1, ase_pkg::OpMvn, 1'b1, 4'd0, 4'd2, 12'h000), 1'b0);
		send(dp_word(ase_pkg::CondAl, 1'b0, ase_pkg::OpAdd, 1'b1, 4'd1, 4'd3, 12'h001), 1'b0);
		send(dp_word(ase_pkg::CondVs, 1'b0, ase_pkg::OpSub, 1'b1, 4'd0, 4'd4, 12'h000), 1'b0);
		send(dp_word(ase_pkg::CondAl, 1'b1, ase_pkg::OpCmp, 1'b1, 4'd0, 4'd0, 12'h001), 1'b0);
		send(dp_word(ase_pkg::CondAl, 1'b1, ase_pkg::OpCmn, 1'b1, 4'd2, 4'd0, 12'h001), 1'b0);
		send(dp_word(ase_pkg::CondAl, 1'b1, ase_pkg::OpCmp, 1'b0, 4'd0, 4'd0, 12'h001), 1'b0);
		send(dp_word(ase_pkg::CondAl, 1'b1, ase_pkg::OpAdd, 1'b0, ase_pkg::PcIndex, 4'd5,
			12'h000), 1'b0);
		send(dp_word(ase_pkg::CondAl, 1'b0, ase_pkg::OpAdd, 1'b1, 4'd0, 4'd6, 12'h101), 1'b0);
		send(dp_word(ase_pkg::CondAl, 1'b1, OpAnd, 1'b1, 4'd0, 4'd6, 12'h0FF), 1'b0);
		send({ase_pkg::CondAl, 28'h590_1000}, 1'b0);
		send(dp_word(CondNever, 1'b1, ase_pkg::OpMov, 1'b0, 4'd0, 4'd7, 12'h001), 1'b0);
		send(dp_word(ase_pkg::CondNe, 1'b1, ase_pkg::OpMov, 1'b0, 4'd0, 4'd7, 12'h001), 1'b0);
		send(dp_word(ase_pkg::CondHi, 1'b1, ase_pkg::OpMov, 1'b0, 4'd0, 4'd7, 12'h001), 1'b0);
		send(dp_word(ase_pkg::CondAl, 1'b1, ase_pkg::OpMov, 1'b1, 4'd0, 4'd6, 12'hFFF), 1'b0);
		send(dp_word(ase_pkg::CondAl, 1'b1, ase_pkg::OpSub, 1'b1, 4'd2, 4'd8, 12'h4FF), 1'b0);
		send(branch_word(ase_pkg::CondAl, 1'b1, 24'h000010), 1'b0);
		send(branch_word(ase_pkg::CondAl, 1'b0, 24'hFFFFF0), 1'b0);
		send(bx_word(ase_pkg::CondAl, 4'd0), 1'b0);
		send(dp_word(ase_pkg::CondAl, 1'b1, ase_pkg::OpMov, 1'b1, 4'd0, ase_pkg::PcIndex,
			12'h0FF), 1'b0);
		send(dp_word(ase_pkg::CondLe, 1'b0, ase_pkg::OpMov, 1'b1, 4'd0, 4'd9,
			{8'h00, ase_pkg::PcIndex}), 1'b0);
		send(32'hFFFF_FFFF, 1'b0);
		send(32'h0000_0000, 1'b0);
		drain();

		configure('1, '1, '1, '1, '1);
		run_random(PhaseItems, 1'b1);
		drain();

		in_idle_pct = 49;
		out_idle_pct = 34;
		configure('0, '0, '0, '0, '0);
		run_random(PhaseItems, 1'b0);
		drain();

		in_idle_pct = 0;
		out_idle_pct = 0;
		configure($urandom, $urandom, $urandom, $urandom, $urandom);
		run_random(PhaseItems, 1'b0);
		drain();

		if (sb.failures == 0 && sb.expected_results.size() == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

endmodule

### files.f
rtl/core/ase_pkg.sv
rtl/core/ase_if.sv
rtl/core/ase_ram.sv
rtl/core/ase_regfile.sv
rtl/core/ase_exec.sv
rtl/core/arm_subset_execute_unit.sv
dv/testbench.sv
